@@ hw/rtl/lsa_pkg.sv @@
package lsa_pkg;

   localparam int BUFFER_BYTES_DEF = 65536;
   localparam int MAX_LIVE_DEF     = 64;
   localparam int HEADER_BYTES_DEF = 16;

   localparam int OFF_W   = 17;
   localparam int BASE_W  = 7;
   localparam int PAD_W   = 8;
   localparam int DATA_W  = 16;
   localparam int ALIGN_W = 4;
   localparam int HDR_W   = OFF_W + PAD_W;

   localparam logic [2:0] ALIGN_CAP_LOG2 = 3'd7;

   localparam logic [1:0] OP_ALLOC    = 2'd0;
   localparam logic [1:0] OP_FREE     = 2'd1;
   localparam logic [1:0] OP_FREE_ALL = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_SPACE  = 2'd1;
   localparam logic [1:0] ST_BOUNDS = 2'd2;
   localparam logic [1:0] ST_ORDER  = 2'd3;

   localparam logic CSR_BUFFER_LENGTH = 1'b0;
   localparam logic CSR_BASE_ADDR_LOW = 1'b1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [OFF_W-1:0]   request_size;
      logic [ALIGN_W-1:0] align_log2;
      logic               block_present;
      logic [DATA_W-1:0]  block_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] data_offset;
      logic [PAD_W-1:0]  padding_used;
   } rsp_type;

endpackage

@@ hw/rtl/lsa_hdr_mem.sv @@
module lsa_hdr_mem #(
   parameter int DEPTH = lsa_pkg::MAX_LIVE_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [lsa_pkg::HDR_W-1:0] rd_data,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [lsa_pkg::HDR_W-1:0] wr_data
);

   logic [lsa_pkg::HDR_W-1:0] mem_ff [DEPTH];
   logic [lsa_pkg::HDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lsa_core.sv @@
module lsa_core #(
   parameter int BUFFER_BYTES = lsa_pkg::BUFFER_BYTES_DEF,
   parameter int MAX_LIVE     = lsa_pkg::MAX_LIVE_DEF,
   parameter int HEADER_BYTES = lsa_pkg::HEADER_BYTES_DEF,
   parameter int AW           = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lsa_pkg::req_type          req_payload,
   output logic                      rsp_strobe,
   output lsa_pkg::rsp_type          rsp_payload,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [lsa_pkg::OFF_W-1:0] csr_wdata,
   output logic                      hdr_rd_en,
   output logic [AW-1:0]             hdr_rd_addr,
   input  logic [lsa_pkg::HDR_W-1:0] hdr_rd_data,
   output logic                      hdr_wr_en,
   output logic [AW-1:0]             hdr_wr_addr,
   output logic [lsa_pkg::HDR_W-1:0] hdr_wr_data
);

   localparam int CW = $clog2(MAX_LIVE + 1);

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type                    state_ff, state_in;
   lsa_pkg::req_type             req_ff, req_in;
   logic [lsa_pkg::PAD_W-1:0]    pad_ff, pad_in;
   logic [lsa_pkg::OFF_W-1:0]    cur_ff, cur_in;
   logic [lsa_pkg::OFF_W-1:0]    prev_ff, prev_in;
   logic [CW-1:0]                live_ff, live_in;
   logic [lsa_pkg::OFF_W-1:0]    buf_len_ff, buf_len_in;
   logic [lsa_pkg::BASE_W-1:0]   base_ff, base_in;
   lsa_pkg::rsp_type             rsp_ff, rsp_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;

   logic                         accept;
   logic [CW-1:0]                live_dec;

   // padding, computed at accept from the offset left by the previous transaction
   logic [2:0]                   sh;
   logic [8:0]                   align_bytes;
   logic [lsa_pkg::BASE_W-1:0]   addr_low;
   logic [8:0]                   mis;
   logic [8:0]                   pad_base;
   logic [8:0]                   pad_need;
   logic [8:0]                   pad_full;

   // evaluation
   logic [lsa_pkg::OFF_W-1:0]    eff_len;
   logic [lsa_pkg::OFF_W:0]      start_off;
   logic [lsa_pkg::OFF_W+1:0]    end_off;
   logic                         alloc_fail;
   logic [lsa_pkg::OFF_W-1:0]    blk;
   logic [lsa_pkg::PAD_W-1:0]    hdr_pad;
   logic [lsa_pkg::OFF_W-1:0]    hdr_prev;
   logic [lsa_pkg::OFF_W-1:0]    blk_base;

   assign accept   = start && (state_ff == IDLE);
   assign live_dec = live_ff - CW'(1);

   always_comb begin
      sh          = (req_payload.align_log2 > {1'b0, lsa_pkg::ALIGN_CAP_LOG2}) ?
                    lsa_pkg::ALIGN_CAP_LOG2 : req_payload.align_log2[2:0];
      align_bytes = 9'd1 << sh;
      addr_low    = base_ff + cur_ff[lsa_pkg::BASE_W-1:0];
      mis         = {2'b00, addr_low} & (align_bytes - 9'd1);
      pad_base    = (mis != 9'd0) ? (align_bytes - mis) : 9'd0;
      pad_need    = 9'(HEADER_BYTES) - pad_base + align_bytes - 9'd1;
      pad_need    = (pad_need >> sh) << sh;
      pad_full    = (pad_base < 9'(HEADER_BYTES)) ? (pad_base + pad_need) : pad_base;
   end

   always_comb begin
      eff_len    = (32'(buf_len_ff) > 32'(BUFFER_BYTES)) ?
                   lsa_pkg::OFF_W'(BUFFER_BYTES) : buf_len_ff;
      start_off  = {1'b0, cur_ff} + (lsa_pkg::OFF_W+1)'(pad_ff);
      end_off    = {1'b0, start_off} + (lsa_pkg::OFF_W+2)'(req_ff.request_size);
      alloc_fail = (live_ff >= CW'(MAX_LIVE)) ||
                   (end_off > (lsa_pkg::OFF_W+2)'(eff_len)) ||
                   (start_off > (lsa_pkg::OFF_W+1)'(17'hFFFF));
      blk        = {1'b0, req_ff.block_offset};
      hdr_pad    = hdr_rd_data[lsa_pkg::PAD_W-1:0];
      hdr_prev   = hdr_rd_data[lsa_pkg::HDR_W-1:lsa_pkg::PAD_W];
      blk_base   = blk - lsa_pkg::OFF_W'(hdr_pad);
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      pad_in        = pad_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      live_in       = live_ff;
      buf_len_in    = buf_len_ff;
      base_in       = base_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      hdr_wr_en     = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            lsa_pkg::CSR_BUFFER_LENGTH: buf_len_in = csr_wdata;
            lsa_pkg::CSR_BASE_ADDR_LOW: base_in    = csr_wdata[lsa_pkg::BASE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               req_in   = req_payload;
               pad_in   = pad_full[lsa_pkg::PAD_W-1:0];
               state_in = EXEC;
            end
         end
         EXEC: begin
            state_in            = IDLE;
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = lsa_pkg::ST_OK;
            rsp_in.data_offset  = '0;
            rsp_in.padding_used = '0;
            case (req_ff.operation)
               lsa_pkg::OP_ALLOC: begin
                  if (alloc_fail) begin
                     rsp_in.status = lsa_pkg::ST_SPACE;
                  end else begin
                     hdr_wr_en           = 1'b1;
                     live_in             = live_ff + CW'(1);
                     prev_in             = cur_ff;
                     cur_in              = end_off[lsa_pkg::OFF_W-1:0];
                     rsp_in.data_offset  = start_off[lsa_pkg::DATA_W-1:0];
                     rsp_in.padding_used = pad_ff;
                  end
               end
               lsa_pkg::OP_FREE: begin
                  if (req_ff.block_present) begin
                     if (blk >= eff_len) begin
                        rsp_in.status = lsa_pkg::ST_BOUNDS;
                     end else if (live_ff == '0) begin
                        rsp_in.status = lsa_pkg::ST_ORDER;
                     end else if ((blk < lsa_pkg::OFF_W'(hdr_pad)) || (blk_base != prev_ff)) begin
                        rsp_in.status = lsa_pkg::ST_ORDER;
                     end else begin
                        cur_in  = prev_ff;
                        prev_in = hdr_prev;
                        live_in = live_dec;
                     end
                  end
               end
               lsa_pkg::OP_FREE_ALL: begin
                  cur_in  = '0;
                  prev_in = '0;
                  live_in = '0;
               end
               default: ;
            endcase
         end
         default: state_in = IDLE;
      endcase
   end

   // top header is read at accept; the last write has already landed in the RAM by then
   assign hdr_rd_en   = accept;
   assign hdr_rd_addr = live_dec[AW-1:0];
   assign hdr_wr_addr = live_ff[AW-1:0];
   assign hdr_wr_data = {prev_ff, pad_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         cur_ff        <= '0;
         prev_ff       <= '0;
         live_ff       <= '0;
         buf_len_ff    <= '0;
         base_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         prev_ff       <= prev_in;
         live_ff       <= live_in;
         buf_len_ff    <= buf_len_in;
         base_ff       <= base_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in;
      pad_ff <= pad_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff == EXEC);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_exec: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_strobe))
      else $error("evaluation did not finish in one cycle");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CW'(MAX_LIVE))
      else $error("live count above header stack depth");

   a_pad_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.padding_used != '0)) |->
         (rsp_payload.status == lsa_pkg::ST_OK &&
          rsp_payload.data_offset >= lsa_pkg::DATA_W'(rsp_payload.padding_used)))
      else $error("padding reported on a failed or misplaced allocation");

endmodule

@@ hw/rtl/lifo_stack_allocator.sv @@
// LIFO stack allocator with alignment header. For each transaction (allocate,
// free, free all) start is taken when busy is low, busy is high for one cycle
// while the top header comes out of the header-stack RAM and the result is
// evaluated and written back, and rsp_strobe marks the result for one cycle
// right after, in the same cycle a new start can be taken. With one RAM
// read-modify-write per transaction, no new start is taken while busy. The
// receiver cannot stall: rsp_strobe marks a result for that single cycle only;
// rsp_payload holds it until the next result. The header RAM needs no clearing
// after reset; entries above the live count are never used. Configuration
// writes on the csr port take effect at once and are meant for idle periods.
module lifo_stack_allocator #(
   parameter int BUFFER_BYTES = lsa_pkg::BUFFER_BYTES_DEF,
   parameter int MAX_LIVE     = lsa_pkg::MAX_LIVE_DEF,
   parameter int HEADER_BYTES = lsa_pkg::HEADER_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lsa_pkg::req_type          req_payload,
   output logic                      rsp_strobe,
   output lsa_pkg::rsp_type          rsp_payload,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [lsa_pkg::OFF_W-1:0] csr_wdata
);

   localparam int AW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;

   logic                      hdr_rd_en;
   logic [AW-1:0]             hdr_rd_addr;
   logic [lsa_pkg::HDR_W-1:0] hdr_rd_data;
   logic                      hdr_wr_en;
   logic [AW-1:0]             hdr_wr_addr;
   logic [lsa_pkg::HDR_W-1:0] hdr_wr_data;

   lsa_core #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_LIVE     (MAX_LIVE),
      .HEADER_BYTES (HEADER_BYTES),
      .AW           (AW)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .hdr_rd_en   (hdr_rd_en),
      .hdr_rd_addr (hdr_rd_addr),
      .hdr_rd_data (hdr_rd_data),
      .hdr_wr_en   (hdr_wr_en),
      .hdr_wr_addr (hdr_wr_addr),
      .hdr_wr_data (hdr_wr_data)
   );

   lsa_hdr_mem #(
      .DEPTH (MAX_LIVE),
      .AW    (AW)
   ) u_hdr_mem (
      .clock   (clock),
      .rd_en   (hdr_rd_en),
      .rd_addr (hdr_rd_addr),
      .rd_data (hdr_rd_data),
      .wr_en   (hdr_wr_en),
      .wr_addr (hdr_wr_addr),
      .wr_data (hdr_wr_data)
   );

endmodule
